// File: src/nat_pkg.sv
// Package for the node address table: default sizes, opcodes and the
// packed transfer types of the input and result channels.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package nat_pkg;

  localparam int TableDepthDef = 16;
  localparam int DataWidthDef  = 32;
  localparam int KeyWidth      = 64;
  localparam int SlotWidth     = 4;
  localparam int DataOutWidth  = 32;

  typedef enum logic [1:0] {
    OpAdd       = 2'd0,
    OpLookupKey = 2'd1,
    OpLookupIdx = 2'd2,
    OpNop       = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [KeyWidth-1:0]     node_key;
    logic [SlotWidth-1:0]    slot_index;
    logic [DataOutWidth-1:0] node_data;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic [SlotWidth-1:0]    slot_out;
    logic [KeyWidth-1:0]     key_out;
    logic [DataOutWidth-1:0] data_out;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/nat_mem.sv
// Entry memory of the node address table: one synchronous array of key and
// payload, one write and one registered read port, plus per-slot valid bits.
// Depends on nat_pkg.
`default_nettype none

module nat_mem
  import nat_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int DATA_WIDTH  = DataWidthDef,
  localparam int AddrWidth  = $clog2(TABLE_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  rd_en_i,
  input  wire logic [AddrWidth-1:0]  rd_addr_i,
  output logic      [KeyWidth-1:0]   rd_key_o,
  output logic      [DATA_WIDTH-1:0] rd_data_o,
  input  wire logic                  wr_en_i,
  input  wire logic [AddrWidth-1:0]  wr_addr_i,
  input  wire logic [KeyWidth-1:0]   wr_key_i,
  input  wire logic [DATA_WIDTH-1:0] wr_data_i
);

  localparam int EntryWidth = KeyWidth + DATA_WIDTH;

  logic [EntryWidth-1:0]  mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [EntryWidth-1:0]  rd_entry_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_key_i, wr_data_i};
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_addr_i];
    end
  end

  // A slot that was never written since reset reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_key_o  = rd_vld_q ? rd_entry_q[EntryWidth-1:DATA_WIDTH] : '0;
  assign rd_data_o = rd_vld_q ? rd_entry_q[DATA_WIDTH-1:0] : '0;

endmodule

`default_nettype wire

// File: src/nat_ctrl.sv
// Sequencer of the node address table: takes one request, scans the entry
// memory one slot per cycle or reads one slot, writes back on add and forms
// the result. Depends on nat_pkg; drives the ports of nat_mem.
`default_nettype none

module nat_ctrl
  import nat_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int DATA_WIDTH  = DataWidthDef,
  localparam int AddrWidth  = $clog2(TABLE_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output out_item_t                  res_o,
  output logic                       rd_en_o,
  output logic      [AddrWidth-1:0]  rd_addr_o,
  input  wire logic [KeyWidth-1:0]   rd_key_i,
  input  wire logic [DATA_WIDTH-1:0] rd_data_i,
  output logic                       wr_en_o,
  output logic      [AddrWidth-1:0]  wr_addr_o,
  output logic      [KeyWidth-1:0]   wr_key_o,
  output logic      [DATA_WIDTH-1:0] wr_data_o
);

  localparam int PtrWidth = AddrWidth + 1;
  localparam logic [PtrWidth-1:0]  DepthPtr = PtrWidth'(TABLE_DEPTH);
  localparam logic [AddrWidth-1:0] LastSlot = AddrWidth'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StIdxRd,
    StIdxChk,
    StResp
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic [KeyWidth-1:0]     key_q, key_d;
  logic [SlotWidth-1:0]    idx_q, idx_d;
  logic [DataOutWidth-1:0] data_q, data_d;
  logic [PtrWidth-1:0]     ptr_q, ptr_d;
  logic [AddrWidth-1:0]    cmp_slot_q, cmp_slot_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic                    have_empty_q, have_empty_d;
  logic [AddrWidth-1:0]    empty_slot_q, empty_slot_d;
  out_item_t               res_q, res_d;
  logic [DATA_WIDTH-1:0]   new_data;

  assign new_data  = DATA_WIDTH'(data_q);
  assign wr_key_o  = key_q;
  assign wr_data_o = new_data;

  always_comb begin
    logic                 free_now;
    logic [AddrWidth-1:0] free_slot;

    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    idx_d        = idx_q;
    data_d       = data_q;
    ptr_d        = ptr_q;
    cmp_slot_d   = cmp_slot_q;
    cmp_vld_d    = cmp_vld_q;
    have_empty_d = have_empty_q;
    empty_slot_d = empty_slot_q;
    res_d        = res_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    rd_en_o      = 1'b0;
    rd_addr_o    = ptr_q[AddrWidth-1:0];
    wr_en_o      = 1'b0;
    wr_addr_o    = cmp_slot_q;
    free_now     = have_empty_q || (rd_key_i == '0);
    free_slot    = have_empty_q ? empty_slot_q : cmp_slot_q;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = in_item_i.opcode;
          key_d        = in_item_i.node_key;
          idx_d        = in_item_i.slot_index;
          data_d       = in_item_i.node_data;
          ptr_d        = '0;
          cmp_vld_d    = 1'b0;
          have_empty_d = 1'b0;
          res_d        = '0;
          state_d      = StResp;
          unique case (in_item_i.opcode)
            OpAdd, OpLookupKey: begin
              if (in_item_i.node_key != '0) begin
                state_d = StScan;
              end
            end
            OpLookupIdx: begin
              if (32'(in_item_i.slot_index) < TABLE_DEPTH) begin
                state_d = StIdxRd;
              end
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end
      StScan: begin
        rd_en_o = (ptr_q < DepthPtr);
        if (rd_en_o) begin
          ptr_d      = ptr_q + PtrWidth'(1);
          cmp_slot_d = ptr_q[AddrWidth-1:0];
          cmp_vld_d  = 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (rd_key_i == key_q) begin
            res_d.found    = 1'b1;
            res_d.slot_out = SlotWidth'(cmp_slot_q);
            res_d.key_out  = rd_key_i;
            if (op_q == OpAdd) begin
              wr_en_o        = 1'b1;
              wr_addr_o      = cmp_slot_q;
              res_d.data_out = DataOutWidth'(new_data);
            end else begin
              res_d.data_out = DataOutWidth'(rd_data_i);
            end
            state_d = StResp;
          end else begin
            if ((rd_key_i == '0) && !have_empty_q) begin
              have_empty_d = 1'b1;
              empty_slot_d = cmp_slot_q;
            end
            if (cmp_slot_q == LastSlot) begin
              if ((op_q == OpAdd) && free_now) begin
                wr_en_o        = 1'b1;
                wr_addr_o      = free_slot;
                res_d.found    = 1'b1;
                res_d.slot_out = SlotWidth'(free_slot);
                res_d.key_out  = key_q;
                res_d.data_out = DataOutWidth'(new_data);
              end
              state_d = StResp;
            end
          end
        end
      end
      StIdxRd: begin
        rd_en_o   = 1'b1;
        rd_addr_o = AddrWidth'(idx_q);
        state_d   = StIdxChk;
      end
      StIdxChk: begin
        if (rd_key_i != '0) begin
          res_d.found    = 1'b1;
          res_d.slot_out = idx_q;
          res_d.key_out  = rd_key_i;
          res_d.data_out = DataOutWidth'(rd_data_i);
        end
        state_d = StResp;
      end
      StResp: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      op_q         <= '0;
      key_q        <= '0;
      idx_q        <= '0;
      data_q       <= '0;
      ptr_q        <= '0;
      cmp_slot_q   <= '0;
      cmp_vld_q    <= 1'b0;
      have_empty_q <= 1'b0;
      empty_slot_q <= '0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      idx_q        <= idx_d;
      data_q       <= data_d;
      ptr_q        <= ptr_d;
      cmp_slot_q   <= cmp_slot_d;
      cmp_vld_q    <= cmp_vld_d;
      have_empty_q <= have_empty_d;
      empty_slot_q <= empty_slot_d;
      res_q        <= res_d;
    end
  end

  assign res_o = res_q;

  a_wr_only_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (op_q == OpAdd) && (key_q != '0))
    else $error("Entry write outside an add of a nonzero address.");

  a_no_rw_same_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_o && rd_en_o) |-> (wr_addr_o != rd_addr_o))
    else $error("Write and read of the same slot in one cycle.");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && cmp_vld_q) |-> (PtrWidth'(cmp_slot_q) + PtrWidth'(1) == ptr_q))
    else $error("Compared slot is not the one read in the previous cycle.");

  a_hit_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StResp) && res_q.found) |-> (res_q.key_out != '0))
    else $error("Hit reported for an empty slot.");

  a_write_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> (state_q == StResp) && res_q.found && (res_q.key_out == key_q))
    else $error("Add wrote an entry but did not report it.");

endmodule

`default_nettype wire

// File: src/node_address_table.sv
// Top level of the node address table: sequencer, entry memory and the
// result output register. Depends on nat_pkg, nat_mem and nat_ctrl.
//
//   channel  direction  payload      handshake
//   in       input      in_item_t    in_valid_i / in_ready_o
//   out      output     out_item_t   out_valid_o / out_ready_i
//
// One request is worked at a time. An add or address lookup scans the entry
// memory one slot per cycle from slot 0 upward; a match ends the scan early.
// A lookup by index reads just its slot; a rejected request skips the memory.
// Reset clears all per-slot valid bits at once, so no clearing pass follows.
// A result waits in the output register; the next request is taken meanwhile.
`default_nettype none

module node_address_table
  import nat_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int DATA_WIDTH  = DataWidthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int AddrWidth = $clog2(TABLE_DEPTH);

  logic                  res_valid;
  logic                  res_ready;
  out_item_t             res;
  logic                  rd_en;
  logic [AddrWidth-1:0]  rd_addr;
  logic [KeyWidth-1:0]   rd_key;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [AddrWidth-1:0]  wr_addr;
  logic [KeyWidth-1:0]   wr_key;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  nat_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_key_i   (rd_key),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_key_o   (wr_key),
    .wr_data_o  (wr_data)
  );

  nat_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_key_o (rd_key),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_key_i (wr_key),
    .wr_data_i(wr_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
